[src/wavp_pkg.sv]
package wavp_pkg;

  localparam int HDR_LEN = 44;
  localparam int POS_W   = 6;

  typedef enum logic [1:0] {
    KIND_HDR_OK  = 2'd0,
    KIND_SAMPLE  = 2'd1,
    KIND_NOT_PCM = 2'd2,
    KIND_BAD_SZ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    DIV_NSAMP  = 2'd0,
    DIV_RELOAD = 2'd1,
    DIV_STRIDE = 2'd2
  } div_sel_t;

  localparam logic [POS_W-1:0] POS_OVERALL = 6'd4;
  localparam logic [POS_W-1:0] POS_FMT     = 6'd20;
  localparam logic [POS_W-1:0] POS_CH      = 6'd22;
  localparam logic [POS_W-1:0] POS_RATE    = 6'd24;
  localparam logic [POS_W-1:0] POS_BRATE   = 6'd28;
  localparam logic [POS_W-1:0] POS_BITS    = 6'd34;
  localparam logic [POS_W-1:0] POS_DSIZE   = 6'd40;
  localparam logic [POS_W-1:0] POS_LAST    = 6'd43;

  localparam logic [15:0] FMT_PCM = 16'd1;

  localparam int DIV_NW = 35;
  localparam int DIV_DW = 32;

  typedef struct packed {
    logic             cap_hdr;
    logic [POS_W-1:0] pos;
    logic             mul_go;
    logic             div_start;
    div_sel_t         div_sel;
    logic             hdr_emit;
    logic             data_en;
  } wavp_cmd_t;

  typedef struct packed {
    logic  div_done;
    logic  out_free;
    kind_t kind;
  } wavp_sts_t;

endpackage

[src/wavp_div.sv]
module wavp_div
  import wavp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              done,
  output logic [DIV_NW-1:0] quo,
  output logic [DIV_DW-1:0] rem
);

  localparam int CNT_W = $clog2(DIV_NW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW:0]   rem_r, rem_nxt;
  logic [DIV_DW-1:0] dvs_r, dvs_nxt;
  logic [DIV_DW:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r[DIV_DW-1:0], quo_r[DIV_NW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r[DIV_DW-1:0];

endmodule

[src/wavp_ctrl.sv]
module wavp_ctrl
  import wavp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_file_start,
  input  wavp_sts_t sts,
  output wavp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_HDR, S_MUL, S_DIV_A, S_DIV_B, S_DIV_C, S_EMIT, S_DATA, S_IDLE
  } state_t;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             acc;
  logic [POS_W-1:0] wpos;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cmd       = '0;
    cmd.div_sel = DIV_NSAMP;
    in_ready  = (state_r inside {S_HDR, S_DATA, S_IDLE}) && sts.out_free;
    acc       = in_valid && in_ready;
    wpos      = in_file_start ? '0 : pos_r;
    cmd.pos   = wpos;
    case (state_r)
      S_HDR, S_DATA, S_IDLE: begin
        if (acc) begin
          if (in_file_start || state_r == S_HDR) begin
            cmd.cap_hdr = 1'b1;
            if (wpos == POS_LAST) begin
              state_nxt = S_MUL;
              pos_nxt   = '0;
            end else begin
              state_nxt = S_HDR;
              pos_nxt   = wpos + 1'b1;
            end
          end else if (state_r == S_DATA) begin
            cmd.data_en = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_DIV_A;
      end
      S_DIV_A: begin
        cmd.div_sel = DIV_NSAMP;
        if (!sts.div_done && pos_r == '0) begin
          cmd.div_start = 1'b1;
          pos_nxt = POS_LAST;
        end else if (sts.div_done) begin
          state_nxt = S_DIV_B;
          cmd.div_start = 1'b0;
        end
      end
      S_DIV_B: begin
        cmd.div_sel = DIV_RELOAD;
        if (pos_r == POS_LAST) begin
          cmd.div_start = 1'b1;
          pos_nxt = '0;
        end else if (sts.div_done) begin
          state_nxt = S_DIV_C;
        end
      end
      S_DIV_C: begin
        cmd.div_sel = DIV_STRIDE;
        if (pos_r == '0) begin
          cmd.div_start = 1'b1;
          pos_nxt = POS_LAST;
        end else if (sts.div_done) begin
          state_nxt = S_EMIT;
          pos_nxt   = '0;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.hdr_emit = 1'b1;
          state_nxt = (sts.kind == KIND_HDR_OK) ? S_DATA : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HDR;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

[src/wavp_dp.sv]
module wavp_dp
  import wavp_pkg::*;
#(
  parameter int CHUNK_LEN = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  wavp_cmd_t   cmd,
  output wavp_sts_t   sts,
  input  logic [7:0]  in_data_byte,
  input  logic [11:0] full_scale,
  input  logic [31:0] clock_hz,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [1:0]  out_result_kind,
  output logic [11:0] out_dac_code,
  output logic [31:0] out_sample_rate,
  output logic [15:0] out_channels,
  output logic [15:0] out_bits_per_sample,
  output logic [31:0] out_byte_rate,
  output logic [31:0] out_data_size,
  output logic [31:0] out_overall_size,
  output logic [15:0] out_format_type,
  output logic [31:0] out_num_samples,
  output logic [31:0] out_timer_reload
);

  localparam int OFF_W = $clog2(CHUNK_LEN);

  logic [31:0] overall_r, rate_r, brate_r, dsize_r;
  logic [15:0] fmt_r, ch_r, bits_r;
  logic [31:0] prod_r, nsamp_r, reload_r;
  logic [15:0] stride_q_r, stride_r;
  logic        rem_ok_r;
  logic [7:0]  prev_r;
  logic [OFF_W-1:0] off_r;
  logic [15:0] ph_r;
  logic        out_valid_r, is_hdr_r;
  kind_t       kind_r;
  logic [11:0] dac_r;

  logic [DIV_NW-1:0] div_n, div_q;
  logic [DIV_DW-1:0] div_d, div_r;
  logic              div_done;
  div_sel_t          res_sel_r;
  kind_t             kind;
  logic              emit;
  logic [16:0]       biased;
  logic [28:0]       scaled;
  logic [POS_W-1:0]  p;

  always_comb begin
    case (cmd.div_sel)
      DIV_NSAMP:  begin div_n = {dsize_r, 3'b000};         div_d = prod_r; end
      DIV_RELOAD: begin div_n = {3'b000, clock_hz};        div_d = rate_r; end
      default:    begin div_n = {6'd0, prod_r[31:3]};      div_d = {16'd0, ch_r}; end
    endcase
  end

  wavp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  always_comb begin
    if (fmt_r != FMT_PCM) kind = KIND_NOT_PCM;
    else if (ch_r == '0 || prod_r[31:3] == '0 || rate_r == '0 || !rem_ok_r)
      kind = KIND_BAD_SZ;
    else kind = KIND_HDR_OK;
  end

  // sample + 65536 as 17 bits: sign bit inverted into bit 16
  assign emit   = cmd.data_en && off_r != '0 && ph_r == '0 && stride_r != '0;
  assign biased = {~in_data_byte[7], in_data_byte, prev_r};
  assign scaled = biased * full_scale;
  assign p      = cmd.pos;

  always_ff @(posedge clk) begin
    if (cmd.cap_hdr) begin
      if (p inside {[POS_OVERALL:POS_OVERALL + 6'd3]})
        overall_r[8*(p-POS_OVERALL) +: 8] <= in_data_byte;
      if (p inside {[POS_FMT:POS_FMT + 6'd1]}) fmt_r[8*(p-POS_FMT) +: 8] <= in_data_byte;
      if (p inside {[POS_CH:POS_CH + 6'd1]}) ch_r[8*(p-POS_CH) +: 8] <= in_data_byte;
      if (p inside {[POS_RATE:POS_RATE + 6'd3]}) rate_r[8*(p-POS_RATE) +: 8] <= in_data_byte;
      if (p inside {[POS_BRATE:POS_BRATE + 6'd3]})
        brate_r[8*(p-POS_BRATE) +: 8] <= in_data_byte;
      if (p inside {[POS_BITS:POS_BITS + 6'd1]}) bits_r[8*(p-POS_BITS) +: 8] <= in_data_byte;
      if (p inside {[POS_DSIZE:POS_DSIZE + 6'd3]})
        dsize_r[8*(p-POS_DSIZE) +: 8] <= in_data_byte;
    end
    if (cmd.mul_go) prod_r <= ch_r * bits_r;
    if (cmd.div_start) res_sel_r <= cmd.div_sel;
    if (div_done) begin
      case (res_sel_r)
        DIV_NSAMP:  nsamp_r  <= (prod_r == '0) ? '0 : div_q[31:0];
        DIV_RELOAD: reload_r <= (rate_r == '0) ? '0 : div_q[31:0] - 32'd1;
        default: begin
          stride_q_r <= div_q[15:0];
          rem_ok_r   <= (div_r == '0);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      off_r       <= '0;
      ph_r        <= '0;
      stride_r    <= '0;
    end else begin
      out_valid_r <= cmd.hdr_emit || emit || (out_valid_r && !out_ready);
      if (cmd.hdr_emit) begin
        if (kind == KIND_HDR_OK) begin
          stride_r <= stride_q_r;
          off_r    <= '0;
        end
      end
      if (cmd.data_en) begin
        prev_r <= in_data_byte;
        off_r  <= (off_r == OFF_W'(CHUNK_LEN - 1)) ? '0 : off_r + 1'b1;
        if (off_r == '0 || ph_r + 16'd1 == stride_r) ph_r <= '0;
        else ph_r <= ph_r + 16'd1;
      end
    end
    if (cmd.hdr_emit) begin
      kind_r   <= kind;
      is_hdr_r <= 1'b1;
      dac_r    <= '0;
    end else if (emit) begin
      kind_r   <= KIND_SAMPLE;
      is_hdr_r <= 1'b0;
      dac_r    <= scaled[28:17];
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.kind     = kind;

  assign out_valid           = out_valid_r;
  assign out_result_kind     = kind_r;
  assign out_dac_code        = dac_r;
  assign out_sample_rate     = is_hdr_r ? rate_r   : '0;
  assign out_channels        = is_hdr_r ? ch_r     : '0;
  assign out_bits_per_sample = is_hdr_r ? bits_r   : '0;
  assign out_byte_rate       = is_hdr_r ? brate_r  : '0;
  assign out_data_size       = is_hdr_r ? dsize_r  : '0;
  assign out_overall_size    = is_hdr_r ? overall_r : '0;
  assign out_format_type     = is_hdr_r ? fmt_r    : '0;
  assign out_num_samples     = is_hdr_r ? nsamp_r  : '0;
  assign out_timer_reload    = is_hdr_r ? reload_r : '0;

endmodule

[src/wav_header_parse_and_dac_convert.sv]
// channel | handshake            | payload
// in      | in_valid / in_ready  | in_data_byte, in_file_start
// out     | out_valid / out_ready| out_result_kind .. out_timer_reload
// cfg     | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
// Header and data bytes: one request per cycle while the output register is free.
// After the 44th header byte the shared radix-2 divider runs three 35-step
// passes; the header result is then registered once the output register is free.
// Synchronous active-low reset; the first bytes after reset form a header.
// in_ready drops while the output register holds a result not taken.
module wav_header_parse_and_dac_convert
  import wavp_pkg::*;
#(
  parameter int CHUNK_LEN = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_file_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [11:0] out_dac_code,
  output logic [31:0] out_sample_rate,
  output logic [15:0] out_channels,
  output logic [15:0] out_bits_per_sample,
  output logic [31:0] out_byte_rate,
  output logic [31:0] out_data_size,
  output logic [31:0] out_overall_size,
  output logic [15:0] out_format_type,
  output logic [31:0] out_num_samples,
  output logic [31:0] out_timer_reload,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [11:0] fs_r;
  logic [31:0] clk_hz_r;
  logic        wr;
  wavp_cmd_t   cmd;
  wavp_sts_t   sts;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? clk_hz_r : {20'd0, fs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r     <= 12'd1500;
      clk_hz_r <= 32'd42000000;
    end else if (wr) begin
      if (paddr[2]) clk_hz_r <= pwdata;
      else fs_r <= pwdata[11:0];
    end
  end

  wavp_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_file_start (in_file_start),
    .sts           (sts),
    .cmd           (cmd)
  );

  wavp_dp #(.CHUNK_LEN(CHUNK_LEN)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_data_byte        (in_data_byte),
    .full_scale          (fs_r),
    .clock_hz            (clk_hz_r),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_result_kind     (out_result_kind),
    .out_dac_code        (out_dac_code),
    .out_sample_rate     (out_sample_rate),
    .out_channels        (out_channels),
    .out_bits_per_sample (out_bits_per_sample),
    .out_byte_rate       (out_byte_rate),
    .out_data_size       (out_data_size),
    .out_overall_size    (out_overall_size),
    .out_format_type     (out_format_type),
    .out_num_samples     (out_num_samples),
    .out_timer_reload    (out_timer_reload)
  );

endmodule

[src/wavp_chk.sv]
module wavp_chk
  import wavp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_result_kind,
  input logic [11:0] out_dac_code,
  input logic [31:0] out_sample_rate,
  input logic [15:0] out_channels
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");

  a_smp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_SAMPLE |-> out_sample_rate == '0 && out_channels == '0)
    else $error("sample carries header fields");

  a_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != KIND_SAMPLE |-> out_dac_code == '0)
    else $error("header carries dac code");

endmodule

bind wav_header_parse_and_dac_convert wavp_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_kind (out_result_kind),
  .out_dac_code    (out_dac_code),
  .out_sample_rate (out_sample_rate),
  .out_channels    (out_channels)
);

[test/wav_header_parse_and_dac_convert_tb.sv]
`timescale 1ns / 1ps

module wav_header_parse_and_dac_convert_tb;
  import wavp_pkg::*;

  localparam int CHUNK = 512;

  typedef struct {
    kind_t       kind;
    logic [11:0] dac;
    logic [31:0] rate;
    logic [15:0] ch;
    logic [15:0] bits;
    logic [31:0] brate;
    logic [31:0] dsize;
    logic [31:0] overall;
    logic [15:0] fmt;
    logic [31:0] nsamp;
    logic [31:0] reload;
  } wav_result_t;

  typedef enum int {HDR_GOOD, HDR_NOT_PCM, HDR_NO_CH, HDR_NO_RATE, HDR_TINY,
                    HDR_UNEVEN, HDR_WILD} hdr_shape_t;

  class wav_scoreboard;
    typedef enum int {ST_HEADER, ST_DATA, ST_IDLE} parse_st_t;
    logic [7:0]  hdr[HDR_LEN];
    int          pos;
    parse_st_t   st;
    logic [7:0]  prev;
    int          offset;
    int          stride;
    logic [11:0] full_scale;
    logic [31:0] pclk;
    wav_result_t pending[$];
    int          errors;

    function new();
      pos = 0; st = ST_HEADER; prev = '0; offset = 0; stride = 0;
      full_scale = 12'd1500; pclk = 32'd42000000; errors = 0;
    endfunction

    function logic [31:0] le(int at, int n);
      logic [31:0] v;
      v = 0;
      for (int i = n - 1; i >= 0; i--) v = (v << 8) | hdr[at + i];
      return v;
    endfunction

    function void decode_header();
      wav_result_t r;
      logic [63:0] prod, each;
      r.overall = le(POS_OVERALL, 4); r.fmt = 16'(le(POS_FMT, 2));
      r.ch = 16'(le(POS_CH, 2)); r.rate = le(POS_RATE, 4);
      r.brate = le(POS_BRATE, 4); r.bits = 16'(le(POS_BITS, 2));
      r.dsize = le(POS_DSIZE, 4); r.dac = '0;
      prod = 64'(r.ch) * 64'(r.bits);
      each = prod / 8;
      r.nsamp = (prod != 0) ? 32'((64'(r.dsize) * 8) / prod) : 32'd0;
      r.reload = (r.rate != 0) ? pclk / r.rate - 32'd1 : 32'd0;
      if (r.fmt != FMT_PCM) r.kind = KIND_NOT_PCM;
      else if (r.ch == 0 || each == 0 || r.rate == 0 || (each / r.ch) * r.ch != each)
        r.kind = KIND_BAD_SZ;
      else r.kind = KIND_HDR_OK;
      if (r.kind == KIND_HDR_OK) begin
        stride = int'(16'(each / r.ch)); offset = 0; st = ST_DATA;
      end else st = ST_IDLE;
      pending.push_back(r);
    endfunction

    function void note_request(logic [7:0] b, logic start);
      wav_result_t r;
      logic signed [16:0] s;
      logic [31:0] biased;
      if (start) begin
        pos = 0; st = ST_HEADER;
      end
      case (st)
        ST_HEADER: begin
          hdr[pos] = b; pos++;
          if (pos >= HDR_LEN) begin
            pos = HDR_LEN; decode_header();
          end
        end
        ST_DATA: begin
          if (offset >= 1 && stride != 0 && (offset - 1) % stride == 0) begin
            s = 17'(signed'({b, prev}));
            biased = 32'(s + 17'sd0) + 32'h10000;
            r = '{kind: KIND_SAMPLE, dac: 12'((biased * full_scale) >> 17), default: 0};
            pending.push_back(r);
          end
          prev = b; offset++;
          if (offset >= CHUNK) offset = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(wav_result_t got);
      wav_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.kind != e.kind || got.dac != e.dac || got.rate != e.rate || got.ch != e.ch ||
          got.bits != e.bits || got.brate != e.brate || got.dsize != e.dsize ||
          got.overall != e.overall || got.fmt != e.fmt || got.nsamp != e.nsamp ||
          got.reload != e.reload) begin
        errors++;
        if (errors <= 10) $display("mismatch exp %p\n         got %p", e, got);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, in_file_start = 0;
  logic [7:0] in_data_byte = 0;
  logic out_valid, out_ready = 0;
  logic [1:0] out_result_kind;
  logic [11:0] out_dac_code;
  logic [31:0] out_sample_rate, out_byte_rate, out_data_size, out_overall_size;
  logic [31:0] out_num_samples, out_timer_reload;
  logic [15:0] out_channels, out_bits_per_sample, out_format_type;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  wav_scoreboard sb = new();
  int sent = 0;
  int stall = 0;

  wav_header_parse_and_dac_convert dut (.*);

  always #2 clk = ~clk;

  function int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{kind: kind_t'(out_result_kind), dac: out_dac_code,
                        rate: out_sample_rate, ch: out_channels, bits: out_bits_per_sample,
                        brate: out_byte_rate, dsize: out_data_size,
                        overall: out_overall_size, fmt: out_format_type,
                        nsamp: out_num_samples, reload: out_timer_reload});
    if (stall > 0) begin
      stall--; out_ready <= 0;
    end else begin
      stall = pick_gap(); out_ready <= (stall == 0);
    end
  end

  task send_byte(logic [7:0] b, logic start);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_data_byte <= b; in_file_start <= start;
    do @(posedge clk); while (!in_ready);
    sb.note_request(b, start);
    sent++;
  endtask

  task cfg_write(logic [2:0] addr, logic [31:0] val);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= val;
    @(posedge clk); penable <= 1;
    @(posedge clk); psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == 3'd0) sb.full_scale = val[11:0];
    else sb.pclk = val;
  endtask

  task wait_idle();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task send_file(hdr_shape_t shape, int ndata, logic first_start, int cut);
    logic [7:0] h[HDR_LEN];
    logic [15:0] fmt, ch, bits;
    logic [31:0] rate;
    for (int i = 0; i < HDR_LEN; i++) h[i] = 8'($urandom);
    fmt = FMT_PCM; ch = 16'($urandom_range(4, 1));
    bits = 16'(8 * $urandom_range(4, 1)); rate = $urandom_range(192000, 1);
    case (shape)
      HDR_NOT_PCM: fmt = ($urandom_range(1)) ? 16'hFFFF : 16'($urandom_range(65535, 2));
      HDR_NO_CH:   ch = 0;
      HDR_NO_RATE: rate = 0;
      HDR_TINY: begin
        ch = 1; bits = 16'($urandom_range(7));
      end
      HDR_UNEVEN: begin
        ch = 3; bits = 12;
      end
      HDR_WILD: begin
        fmt = $urandom_range(1) ? FMT_PCM : 16'($urandom);
        ch = 16'($urandom); bits = 16'($urandom);
        rate = $urandom;
      end
      default: ;
    endcase
    h[POS_FMT] = fmt[7:0]; h[POS_FMT+1] = fmt[15:8];
    h[POS_CH] = ch[7:0]; h[POS_CH+1] = ch[15:8];
    h[POS_BITS] = bits[7:0]; h[POS_BITS+1] = bits[15:8];
    for (int i = 0; i < 4; i++) h[POS_RATE+i] = rate[8*i +: 8];
    for (int i = 0; i < HDR_LEN && i < cut; i++) send_byte(h[i], (i == 0) && first_start);
    for (int i = 0; i < ndata; i++) send_byte(8'($urandom), 1'b0);
  endtask

  task random_files(int goal);
    int r, n;
    while (sent < goal) begin
      r = $urandom_range(99);
      n = ($urandom_range(19) == 0) ? $urandom_range(600, 520) : $urandom_range(80, 4);
      if (r < 65) send_file(HDR_GOOD, n, 1, HDR_LEN);
      else if (r < 72) send_file(HDR_NOT_PCM, $urandom_range(6), 1, HDR_LEN);
      else if (r < 76) send_file(HDR_NO_CH, $urandom_range(6), 1, HDR_LEN);
      else if (r < 80) send_file(HDR_NO_RATE, $urandom_range(6), 1, HDR_LEN);
      else if (r < 84) send_file(HDR_TINY, $urandom_range(6), 1, HDR_LEN);
      else if (r < 88) send_file(HDR_UNEVEN, $urandom_range(6), 1, HDR_LEN);
      else if (r < 94) send_file(HDR_WILD, $urandom_range(20), 1, HDR_LEN);
      else send_file(HDR_GOOD, 0, 1, $urandom_range(40, 1));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_file(HDR_GOOD, 0, 0, HDR_LEN);
    send_byte(8'h00, 0); send_byte(8'h80, 0); send_byte(8'hFF, 0); send_byte(8'h7F, 0);
    send_byte(8'h00, 0); send_byte(8'h00, 0); send_byte(8'hFF, 0); send_byte(8'hFF, 0);
    send_file(HDR_NOT_PCM, 3, 1, HDR_LEN);
    wait_idle();
    random_files(300);
    wait_idle();
    cfg_write(3'd0, 32'hFFFF_FFFF);
    cfg_write(3'd4, 32'hFFFF_FFFF);
    random_files(500);
    wait_idle();
    cfg_write(3'd0, 32'd1);
    cfg_write(3'd4, 32'd1);
    random_files(650);
    wait_idle();
    cfg_write(3'd0, $urandom_range(4095, 1));
    cfg_write(3'd4, $urandom);
    random_files(850);
    wait_idle();
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
